FILE: design/fqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqr_pkg: shared definitions for the FIFO queue with keyed removal
// Field widths, command and status codes, and the control bundle that the
// queue control drives into every storage cell.
// ----------------------------------------------------------------------------
package fqr_pkg;

	localparam int DEPTH   = 16;
	localparam int ID_BITS = 16;

	localparam int CMD_W = 2;
	localparam int PID_W = 16;
	localparam int ST_W  = 2;
	localparam int OID_W = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic               push;
		logic               pop;
		logic               remove;
		logic [ID_BITS-1:0] key;
	} cell_ctrl_t;

endpackage

FILE: design/fqr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqr_req_if: command channel
// Carries one command beat: the operation code and the process identifier.
// ----------------------------------------------------------------------------
interface fqr_req_if import fqr_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [PID_W-1:0] proc_id;

	modport source (output valid, cmd, proc_id, input ready);
	modport sink (input valid, cmd, proc_id, output ready);

endinterface

FILE: design/fqr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqr_rsp_if: result channel
// Carries one result beat: status, returned identifier and occupancy.
// ----------------------------------------------------------------------------
interface fqr_rsp_if import fqr_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [OID_W-1:0] out_id;
	logic [CNT_W-1:0] occupancy;

	modport source (output valid, status, out_id, occupancy, input ready);
	modport sink (input valid, status, out_id, occupancy, output ready);

endinterface

FILE: design/fqr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqr_cell: one queue slot
// Holds one identifier and its valid bit. It loads the pushed identifier when
// it is the first free slot, and takes its right neighbor's contents on a pop
// or when the queue shifts forward at or behind a removed entry.
// ----------------------------------------------------------------------------
module fqr_cell import fqr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic               prev_valid,
	input  logic               hit_in,
	input  logic [ID_BITS-1:0] next_id,
	input  logic               next_valid,
	output logic [ID_BITS-1:0] id,
	output logic               valid,
	output logic               hit_out
);

	logic [ID_BITS-1:0] id_q;
	logic               valid_q;
	logic               load;
	logic               shift;

	// A hit at or ahead of this slot means this slot closes the gap.
	assign hit_out = hit_in | (valid_q & (id_q == ctrl.key));
	assign load    = ctrl.push & ~valid_q & prev_valid;
	assign shift   = ctrl.pop | (ctrl.remove & hit_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (shift) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q <= ctrl.key;
		end else if (shift) begin
			id_q <= next_id;
		end
	end

	assign id    = id_q;
	assign valid = valid_q;

endmodule

FILE: design/fifo_queue_with_remove_by_id.sv
`timescale 1ns / 1ps
// A result beat is registered when its command beat is accepted.
// Throughput: one command per cycle unless stalled; the row of cells compares
// the key in every slot and shifts by one slot in the same cycle.
// The output register frees as its beat is taken, so a stall holds the input.
// Reset clears all valid bits, the entry count and the result valid flag.
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id: bounded FIFO of identifiers with keyed removal
// Push appends at the back, pop takes the front, remove takes out the first
// matching entry and closes the gap. Every command returns one result beat.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id import fqr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	fqr_req_if.sink    req,
	fqr_rsp_if.source  rsp
);

	logic [ID_BITS-1:0] ids    [DEPTH];
	logic               valids [DEPTH];
	logic               hits   [DEPTH];
	cell_ctrl_t         ctrl;
	logic               accept;
	logic               full;
	logic               empty;
	logic               found;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [ST_W-1:0]    status_d;
	logic [OID_W-1:0]   out_id_d;
	logic               rsp_valid_q;
	logic [ST_W-1:0]    status_q;
	logic [OID_W-1:0]   out_id_q;

	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign accept    = req.valid & req.ready;

	assign ctrl.push   = accept & (req.cmd == CMD_PUSH);
	assign ctrl.pop    = accept & (req.cmd == CMD_POP);
	assign ctrl.remove = accept & (req.cmd == CMD_REMOVE);
	assign ctrl.key    = req.proc_id[ID_BITS-1:0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0 && i == DEPTH - 1) begin : g_only
			fqr_cell u_cell (
				.clk, .arst_n, .ctrl,
				.prev_valid(1'b1), .hit_in(1'b0),
				.next_id(ids[i]), .next_valid(1'b0),
				.id(ids[i]), .valid(valids[i]), .hit_out(hits[i])
			);
		end else if (i == 0) begin : g_head
			fqr_cell u_cell (
				.clk, .arst_n, .ctrl,
				.prev_valid(1'b1), .hit_in(1'b0),
				.next_id(ids[i+1]), .next_valid(valids[i+1]),
				.id(ids[i]), .valid(valids[i]), .hit_out(hits[i])
			);
		end else if (i == DEPTH - 1) begin : g_tail
			fqr_cell u_cell (
				.clk, .arst_n, .ctrl,
				.prev_valid(valids[i-1]), .hit_in(hits[i-1]),
				.next_id(ids[i]), .next_valid(1'b0),
				.id(ids[i]), .valid(valids[i]), .hit_out(hits[i])
			);
		end else begin : g_mid
			fqr_cell u_cell (
				.clk, .arst_n, .ctrl,
				.prev_valid(valids[i-1]), .hit_in(hits[i-1]),
				.next_id(ids[i+1]), .next_valid(valids[i+1]),
				.id(ids[i]), .valid(valids[i]), .hit_out(hits[i])
			);
		end
	end

	assign full  = valids[DEPTH-1];
	assign empty = ~valids[0];
	assign found = hits[DEPTH-1];

	always_comb begin
		status_d = ST_OK;
		out_id_d = '0;
		count_d  = count_q;
		unique case (req.cmd)
			CMD_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					status_d = ST_MISS;
				end else begin
					out_id_d = OID_W'(ids[0]);
					count_d  = count_q - CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (!found) begin
					status_d = ST_MISS;
				end else begin
					out_id_d = OID_W'(ctrl.key);
					count_d  = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			out_id_q <= out_id_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.out_id    = out_id_q;
	assign rsp.occupancy = count_q;

endmodule

FILE: design/fqr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqr_checker: port-level checks for the queue
// Watches the result channel and checks handshake stability and the
// consistency of status, identifier and occupancy in every beat.
// ----------------------------------------------------------------------------
module fqr_checker import fqr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [ST_W-1:0]  status,
	input logic [OID_W-1:0] out_id,
	input logic [CNT_W-1:0] occupancy
);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Result beat dropped while stalled.");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(out_id) && $stable(occupancy))
		else $error("Result beat changed while stalled.");

	a_miss_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> out_id == '0)
		else $error("Failed command returned a nonzero identifier.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> occupancy == CNT_W'(DEPTH))
		else $error("Full status reported below capacity.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupancy <= CNT_W'(DEPTH))
		else $error("Occupancy exceeds capacity.");

endmodule

bind fifo_queue_with_remove_by_id fqr_checker u_fqr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.out_id    (rsp.out_id),
	.occupancy (rsp.occupancy)
);

FILE: sim/tb_fifo_queue_with_remove_by_id.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_queue_with_remove_by_id: self-checking bench for the keyed FIFO
// Drives push, pop, remove and unused commands through the request channel and
// keeps a shadow queue that predicts each result beat. Every result beat
// is checked field by field against the oldest prediction. Both channels
// idle at random, the receiver holds off for a long stretch once, and the
// queue is walked from empty to full and back again.
// ----------------------------------------------------------------------------
module tb_fifo_queue_with_remove_by_id;
	import fqr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [OID_W-1:0] out_id;
		logic [CNT_W-1:0] occupancy;
	} queue_result_t;

	logic clk;
	logic arst_n;

	fqr_req_if req ();
	fqr_rsp_if rsp ();

	fifo_queue_with_remove_by_id u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	logic [ID_BITS-1:0] shadow_ids[$];
	queue_result_t      pending_results[$];
	int                 mismatches = 0;
	bit                 req_idle = 1'b0;
	bit                 rsp_idle = 1'b0;
	int                 rsp_hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic queue_result_t predict_queue_op(input logic [CMD_W-1:0] op,
			input logic [PID_W-1:0] id);
		queue_result_t r;
		int            hit;
		r.status = ST_OK;
		r.out_id = '0;
		hit = -1;
		case (op)
			CMD_PUSH: begin
				if (shadow_ids.size() >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					shadow_ids.push_back(id[ID_BITS-1:0]);
				end
			end
			CMD_POP: begin
				if (shadow_ids.size() == 0) begin
					r.status = ST_MISS;
				end else begin
					r.out_id = shadow_ids.pop_front();
				end
			end
			CMD_REMOVE: begin
				for (int i = 0; i < shadow_ids.size(); i++) begin
					if (hit < 0 && shadow_ids[i] == id[ID_BITS-1:0])
						hit = i;
				end
				if (hit < 0) begin
					r.status = ST_MISS;
				end else begin
					r.out_id = shadow_ids[hit];
					shadow_ids.delete(hit);
				end
			end
			default: begin
			end
		endcase
		r.occupancy = CNT_W'(shadow_ids.size());
		return r;
	endfunction

	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [PID_W-1:0] id);
		int gap;
		gap = req_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.cmd     <= op;
		req.proc_id <= id;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(predict_queue_op(op, id));
	endtask

	task automatic wait_results_drained();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	initial begin
		int stall;
		rsp.ready <= 1'b0;
		forever begin
			if (rsp_hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
			end
			stall = rsp_idle ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	always @(posedge clk) begin
		queue_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: status %0d id %h occ %0d",
					$time, rsp.status, rsp.out_id, rsp.occupancy);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp.status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, exp_r.status, rsp.status);
					mismatches++;
				end
				if (rsp.out_id !== exp_r.out_id) begin
					$display("%0t: out_id expected %h actual %h",
						$time, exp_r.out_id, rsp.out_id);
					mismatches++;
				end
				if (rsp.occupancy !== exp_r.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d",
						$time, exp_r.occupancy, rsp.occupancy);
					mismatches++;
				end
			end
		end
	end

	task automatic test_directed();
		req_idle = 1'b1;
		rsp_idle = 1'b1;
		send_cmd(CMD_POP, 16'h0000);
		send_cmd(CMD_REMOVE, 16'h0001);
		send_cmd(CMD_NONE, 16'hAAAA);
		send_cmd(CMD_PUSH, 16'h0000);
		send_cmd(CMD_PUSH, 16'hFFFF);
		send_cmd(CMD_PUSH, 16'h5555);
		send_cmd(CMD_PUSH, 16'hAAAA);
		send_cmd(CMD_PUSH, 16'h5555);
		send_cmd(CMD_NONE, 16'h7FFE);
		send_cmd(CMD_REMOVE, 16'h5555);
		send_cmd(CMD_REMOVE, 16'h0000);
		send_cmd(CMD_REMOVE, 16'h1234);
		send_cmd(CMD_POP, 16'hFFFF);
		send_cmd(CMD_POP, 16'h0000);
		send_cmd(CMD_REMOVE, 16'h5555);
		send_cmd(CMD_POP, 16'h0000);
		send_cmd(CMD_PUSH, 16'h8001);
		send_cmd(CMD_REMOVE, 16'h8001);
		send_cmd(CMD_REMOVE, 16'h8001);
		wait_results_drained();
	endtask

	task automatic test_fill_under_stall();
		logic [ID_BITS-1:0] id;
		req_idle = 1'b0;
		rsp_idle = 1'b0;
		rsp_hold_cycles = 120;
		for (int i = 0; i < DEPTH + 4; i++)
			send_cmd(CMD_PUSH, PID_W'($urandom()));
		for (int i = 0; i < DEPTH + 2; i++) begin
			if (shadow_ids.size() != 0)
				id = shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
			else
				id = ID_BITS'($urandom());
			send_cmd(CMD_REMOVE, id);
		end
		send_cmd(CMD_POP, PID_W'($urandom()));
		wait_results_drained();
	endtask

	task automatic test_random_traffic(input int n_beats, input bit idle_in,
			input bit idle_out);
		int                 push_pct;
		int                 pick;
		logic [PID_W-1:0]   id;
		req_idle = idle_in;
		rsp_idle = idle_out;
		push_pct = 50;
		for (int i = 0; i < n_beats; i++) begin
			if (i % 48 == 0)
				push_pct = $urandom_range(20, 80);
			pick = $urandom_range(0, 99);
			if (pick < push_pct) begin
				id = ($urandom_range(0, 3) == 0) ? PID_W'($urandom_range(0, 7)) :
					PID_W'($urandom());
				send_cmd(CMD_PUSH, id);
			end else if (pick < push_pct + (100 - push_pct) / 2) begin
				send_cmd(CMD_POP, PID_W'($urandom()));
			end else begin
				if (shadow_ids.size() != 0 && $urandom_range(0, 3) != 0)
					id = shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
				else
					id = ($urandom_range(0, 1) == 0) ? PID_W'($urandom_range(0, 7)) :
						PID_W'($urandom());
				send_cmd(CMD_REMOVE, id);
			end
		end
		wait_results_drained();
	endtask

	initial begin
		arst_n      <= 1'b0;
		req.valid   <= 1'b0;
		req.cmd     <= CMD_PUSH;
		req.proc_id <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_under_stall();
		test_random_traffic(475, 1'b1, 1'b1);
		test_random_traffic(475, 1'b0, 1'b0);
		test_random_traffic(475, 1'b1, 1'b0);
		test_random_traffic(475, 1'b0, 1'b1);

		repeat (5) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: fifo_queue_with_remove_by_id.f
design/fqr_pkg.sv
design/fqr_req_if.sv
design/fqr_rsp_if.sv
design/fqr_cell.sv
design/fifo_queue_with_remove_by_id.sv
design/fqr_checker.sv
sim/tb_fifo_queue_with_remove_by_id.sv
